@@ sv/twt_pkg.sv @@
// ----------------------------------------------------------------------------
// twt_pkg: shared types and constants of the timer table
// entry layout, operation and status codes, controller states
// ----------------------------------------------------------------------------
package twt_pkg;

  localparam int MAX_TIMERS   = 32;
  localparam int RESULT_LIMIT = 32;
  localparam int IdxW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CntW = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REFRESH = 2'd1,
    OP_CANCEL  = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_CANCELLED = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_TICK,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic        valid;
    logic        cancelled;
    logic [63:0] id;
    logic [31:0] timeout;
    logic [31:0] remaining;
  } entry_t;

endpackage

@@ sv/twt_cell.sv @@
// ----------------------------------------------------------------------------
// twt_cell: one table entry in the rotating ring
// loads the neighbor's entry on every shift cycle
// ----------------------------------------------------------------------------
module twt_cell
  import twt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t entry_i,
  output entry_t entry_o
);

  logic        valid_q;
  logic        cancelled_q;
  logic [63:0] id_q;
  logic [31:0] timeout_q;
  logic [31:0] remaining_q;

  // flags need reset, payload does not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      cancelled_q <= 1'b0;
    end else if (shift_i) begin
      valid_q     <= entry_i.valid;
      cancelled_q <= entry_i.cancelled;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      id_q        <= entry_i.id;
      timeout_q   <= entry_i.timeout;
      remaining_q <= entry_i.remaining;
    end
  end

  // repack the entry for the neighbor
  always_comb begin
    entry_o.valid     = valid_q;
    entry_o.cancelled = cancelled_q;
    entry_o.id        = id_q;
    entry_o.timeout   = timeout_q;
    entry_o.remaining = remaining_q;
  end

endmodule

@@ sv/timer_wheel_table.sv @@
// ----------------------------------------------------------------------------
// timer_wheel_table: table of one-shot timers kept in a ring of cells
// commands search by id, a tick counts each valid entry down and reports the uncancelled expiries
// ----------------------------------------------------------------------------
// channel   | direction | ports
// command   | in        | start, busy, operation_i, timer_id_i, timeout_i
// result    | out       | result_strobe_o, kind_o, expired_or_addressed_id_o,
//           |           | status_o, last_o
//
// busy stays high through the tick pass and the flush state after a tick
// transfer, and through the search pass, write pass and flush state after a
// command; the next transfer can be taken once busy is low. the ring rotates
// once per pass and the head cell sees one entry per cycle. results leave
// through an output register, one per cycle.
// reset clears all valid and cancel flags at once; no clearing pass.
// the receiver cannot stall; start is taken only while busy is low.
// ----------------------------------------------------------------------------
module timer_wheel_table
  import twt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [63:0] timer_id_i,
  input  logic [31:0] timeout_i,
  output logic        result_strobe_o,
  output logic        kind_o,
  output logic [63:0] expired_or_addressed_id_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_TIMERS - 1);

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  op_e op_q;
  logic [63:0] id_q;
  logic [31:0] tmo_q;
  logic hit_q, hit_d, hitc_q, hitc_d, ffound_q, ffound_d;
  logic [IdxW-1:0] hidx_q, hidx_d, fidx_q, fidx_d;
  logic [CntW-1:0] n_q, n_d;
  logic pend_q, pend_d, pkind_q, pkind_d;
  logic [63:0] pid_q, pid_d;
  logic [1:0] pst_q, pst_d;
  logic ostb_d, okind_d, olast_d;
  logic [63:0] oid_d;
  logic [1:0] ost_d;

  entry_t ring [MAX_TIMERS];
  entry_t head, head_upd;
  logic shift;
  logic [31:0] rem_dec;
  logic expire, emit;
  logic [IdxW-1:0] sel_idx;
  status_e cmd_st;

  // ring of cells, head feeds back into the tail
  for (genvar k = 0; k < MAX_TIMERS; k++) begin : g_cell
    entry_t nxt;
    if (k == MAX_TIMERS - 1) begin : g_tail
      assign nxt = head_upd;
    end else begin : g_mid
      assign nxt = ring[k+1];
    end
    twt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (nxt),
      .entry_o (ring[k])
    );
  end

  assign head  = ring[0];
  assign shift = (state_q == S_SCAN) || (state_q == S_APPLY) || (state_q == S_TICK);
  assign busy  = (state_q != S_IDLE);

  // command outcome from the search pass
  always_comb begin
    sel_idx = hit_q ? hidx_q : fidx_q;
    cmd_st  = ST_OK;
    case (op_q)
      OP_ADD:     cmd_st = (hit_q || ffound_q) ? ST_OK : ST_FULL;
      OP_REFRESH: cmd_st = hit_q ? ST_OK : ST_NOT_FOUND;
      OP_CANCEL:  cmd_st = !hit_q ? ST_NOT_FOUND : (hitc_q ? ST_CANCELLED : ST_OK);
      default:    cmd_st = ST_OK;
    endcase
  end

  // head cell update
  always_comb begin
    head_upd = head;
    rem_dec  = (head.valid && head.remaining != 32'd0) ? head.remaining - 32'd1
                                                       : head.remaining;
    expire   = 1'b0;
    emit     = 1'b0;
    if (state_q == S_TICK) begin
      head_upd.remaining = rem_dec;
      expire = head.valid && (rem_dec == 32'd0);
      if (expire && head.cancelled) begin
        head_upd.valid     = 1'b0;
        head_upd.cancelled = 1'b0;
      end else if (expire && (n_q < CntW'(RESULT_LIMIT))) begin
        emit           = 1'b1;
        head_upd.valid = 1'b0;
      end
    end else if (state_q == S_APPLY && idx_q == sel_idx && cmd_st == ST_OK) begin
      case (op_q)
        OP_ADD: begin
          head_upd.valid     = 1'b1;
          head_upd.cancelled = 1'b0;
          head_upd.id        = id_q;
          head_upd.timeout   = tmo_q;
          head_upd.remaining = tmo_q;
        end
        OP_REFRESH: head_upd.remaining = head.timeout;
        OP_CANCEL:  head_upd.cancelled = 1'b1;
        default:    head_upd = head;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = (op_e'(operation_i) == OP_TICK) ? S_TICK : S_SCAN;
      S_SCAN:  if (idx_q == LastIdx) state_d = S_APPLY;
      S_APPLY: if (idx_q == LastIdx) state_d = S_FLUSH;
      S_TICK:  if (idx_q == LastIdx) state_d = S_FLUSH;
      S_FLUSH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and result outputs
  always_comb begin
    idx_d    = (shift && idx_q != LastIdx) ? idx_q + IdxW'(1) : '0;
    hit_d    = hit_q;
    hitc_d   = hitc_q;
    hidx_d   = hidx_q;
    ffound_d = ffound_q;
    fidx_d   = fidx_q;
    n_d      = n_q;
    pend_d   = pend_q;
    pkind_d  = pkind_q;
    pid_d    = pid_q;
    pst_d    = pst_q;
    ostb_d   = 1'b0;
    okind_d  = pkind_q;
    oid_d    = pid_q;
    ost_d    = pst_q;
    olast_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        hit_d    = 1'b0;
        ffound_d = 1'b0;
        n_d      = '0;
        pend_d   = 1'b0;
      end
      S_SCAN: begin
        if (head.valid && head.id == id_q) begin
          hit_d  = 1'b1;
          hitc_d = head.cancelled;
          hidx_d = idx_q;
        end else if (!head.valid && !ffound_q) begin
          ffound_d = 1'b1;
          fidx_d   = idx_q;
        end
      end
      S_APPLY: begin
        if (idx_q == LastIdx) begin
          pend_d  = 1'b1;
          pkind_d = 1'b0;
          pid_d   = id_q;
          pst_d   = cmd_st;
        end
      end
      S_TICK: begin
        if (emit) begin
          ostb_d  = pend_q;
          pend_d  = 1'b1;
          pkind_d = 1'b1;
          pid_d   = head.id;
          pst_d   = ST_OK;
          n_d     = n_q + CntW'(1);
        end
      end
      S_FLUSH: begin
        ostb_d  = pend_q;
        olast_d = 1'b1;
        pend_d  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      idx_q           <= '0;
      pend_q          <= 1'b0;
      result_strobe_o <= 1'b0;
    end else begin
      state_q         <= state_d;
      idx_q           <= idx_d;
      pend_q          <= pend_d;
      result_strobe_o <= ostb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      op_q  <= op_e'(operation_i);
      id_q  <= timer_id_i;
      tmo_q <= (timeout_i == 32'd0) ? 32'd1 : timeout_i;
    end
    hit_q    <= hit_d;
    hitc_q   <= hitc_d;
    hidx_q   <= hidx_d;
    ffound_q <= ffound_d;
    fidx_q   <= fidx_d;
    n_q      <= n_d;
    pkind_q  <= pkind_d;
    pid_q    <= pid_d;
    pst_q    <= pst_d;
    kind_o   <= okind_d;
    expired_or_addressed_id_o <= oid_d;
    status_o <= ost_d;
    last_o   <= olast_d;
  end

  // checks
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("command transfer not taken");
  a_cmd_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !kind_o |-> last_o) else $error("command result not last");
  a_expiry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && kind_o |-> status_o == ST_OK) else $error("expiry status");

endmodule

@@ verif/twt_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twt_checker: result predictor and comparator for the timer table
// watches command transfers, predicts the results of each one and compares
// every result transfer against the oldest pending prediction
// ----------------------------------------------------------------------------
module twt_checker
  import twt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [63:0] timer_id_i,
  input  logic [31:0] timeout_i,
  input  logic        result_strobe_o,
  input  logic        kind_o,
  input  logic [63:0] expired_or_addressed_id_o,
  input  logic [1:0]  status_o,
  input  logic        last_o,
  output int          fail_cnt,
  output int          pending_cnt
);

  typedef struct packed {
    logic        kind;
    logic [63:0] id;
    status_e     status;
    logic        last;
  } timer_result_t;

  // predictor copy of the table
  logic        live_q      [MAX_TIMERS];
  logic        cancel_q    [MAX_TIMERS];
  logic [63:0] tid_q       [MAX_TIMERS];
  logic [31:0] period_q    [MAX_TIMERS];
  logic [31:0] left_q      [MAX_TIMERS];

  timer_result_t expected_results[$];

  assign pending_cnt = expected_results.size();

  function automatic timer_result_t mk_result(logic k, logic [63:0] id, status_e st,
                                              logic l);
    timer_result_t r;
    r.kind = k;
    r.id = id;
    r.status = st;
    r.last = l;
    return r;
  endfunction

  // append one predicted result transfer
  task automatic queue_result(logic k, logic [63:0] id, status_e st, logic l);
    expected_results = {expected_results, mk_result(k, id, st, l)};
  endtask

  // update the table copy and queue the results of one command transfer
  task automatic predict_command(op_e op, logic [63:0] id, logic [31:0] tmo);
    int hit;
    int slot;
    int n;
    hit = -1;
    slot = -1;
    n = 0;
    if (op == OP_TICK) begin
      for (int i = 0; i < MAX_TIMERS; i++)
        if (live_q[i] && left_q[i] != 0) left_q[i] = left_q[i] - 1;
      for (int i = 0; i < MAX_TIMERS; i++) begin
        if (live_q[i] && left_q[i] == 0) begin
          if (cancel_q[i]) begin
            live_q[i] = 1'b0;
            cancel_q[i] = 1'b0;
          end else if (n < RESULT_LIMIT) begin
            queue_result(1'b1, tid_q[i], ST_OK, 1'b0);
            live_q[i] = 1'b0;
            n++;
          end
        end
      end
      if (n > 0) expected_results[$].last = 1'b1;
      return;
    end
    for (int i = 0; i < MAX_TIMERS; i++)
      if (hit < 0 && live_q[i] && tid_q[i] == id) hit = i;
    case (op)
      OP_ADD: begin
        if (tmo == 0) tmo = 1;
        slot = hit;
        if (slot < 0)
          for (int i = 0; i < MAX_TIMERS; i++)
            if (slot < 0 && !live_q[i]) slot = i;
        if (slot < 0) begin
          queue_result(1'b0, id, ST_FULL, 1'b1);
        end else begin
          live_q[slot] = 1'b1;
          cancel_q[slot] = 1'b0;
          tid_q[slot] = id;
          period_q[slot] = tmo;
          left_q[slot] = tmo;
          queue_result(1'b0, id, ST_OK, 1'b1);
        end
      end
      OP_REFRESH: begin
        if (hit < 0) begin
          queue_result(1'b0, id, ST_NOT_FOUND, 1'b1);
        end else begin
          left_q[hit] = period_q[hit];
          queue_result(1'b0, id, ST_OK, 1'b1);
        end
      end
      default: begin
        if (hit < 0) begin
          queue_result(1'b0, id, ST_NOT_FOUND, 1'b1);
        end else if (cancel_q[hit]) begin
          queue_result(1'b0, id, ST_CANCELLED, 1'b1);
        end else begin
          cancel_q[hit] = 1'b1;
          queue_result(1'b0, id, ST_OK, 1'b1);
        end
      end
    endcase
  endtask

  // sample both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t exp_r;
    if (!rst_ni) begin
      fail_cnt <= 0;
      expected_results.delete();
      for (int i = 0; i < MAX_TIMERS; i++) begin
        live_q[i] = 1'b0;
        cancel_q[i] = 1'b0;
      end
    end else begin
      if (result_strobe_o) begin
        if (expected_results.size() == 0) begin
          if (fail_cnt < 10)
            $display("unexpected result transfer: kind %0d id %h status %0d last %0d",
                     kind_o, expired_or_addressed_id_o, status_o, last_o);
          fail_cnt <= fail_cnt + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (kind_o !== exp_r.kind || expired_or_addressed_id_o !== exp_r.id ||
              status_o !== exp_r.status || last_o !== exp_r.last) begin
            if (fail_cnt < 10)
              $display("mismatch: exp kind %0d id %h status %0d last %0d, %s %0d %h %0d %0d",
                       exp_r.kind, exp_r.id, exp_r.status, exp_r.last, "got",
                       kind_o, expired_or_addressed_id_o, status_o, last_o);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
      if (start && !busy) predict_command(op_e'(operation_i), timer_id_i, timeout_i);
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the timer table
// directed commands and ticks, then random traffic over a small id pool so
// that replace, refresh, cancel, full table and multi-expiry cases recur
// ----------------------------------------------------------------------------
module tb_top;
  import twt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = OP_TICK;
  logic [63:0] timer_id_i = '0;
  logic [31:0] timeout_i = '0;
  logic        result_strobe_o;
  logic        kind_o;
  logic [63:0] expired_or_addressed_id_o;
  logic [1:0]  status_o;
  logic        last_o;
  int          fail_cnt;
  int          pending_cnt;
  int          quiet_cycles = 0;
  logic        gaps_on = 1'b1;
  logic [63:0] id_pool[40];

  always #5 clk_i = ~clk_i;

  timer_wheel_table dut (.*);

  twt_checker u_checker (.*);

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one command transfer with an optional random gap first
  task automatic send_cmd(op_e op, logic [63:0] id, logic [31:0] tmo);
    while (gaps_on && $urandom_range(99) < 24) @(posedge clk_i);
    start <= 1'b1;
    operation_i <= op;
    timer_id_i <= id;
    timeout_i <= tmo;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 1'b0;
    // the block stays busy through its passes after a transfer
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (2 * MAX_TIMERS + 4) @(posedge clk_i);
  endtask

  initial begin
    op_e op;
    logic [63:0] rid;
    logic [31:0] rtmo;
    for (int i = 0; i < 40; i++) id_pool[i] = {$urandom, $urandom};
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, each status but full, zero timeout, cancel at deadline
    send_cmd(OP_TICK, '0, '0);
    send_cmd(OP_REFRESH, '1, '0);
    send_cmd(OP_CANCEL, '0, '1);
    send_cmd(OP_ADD, '0, '0);
    send_cmd(OP_ADD, '1, 32'd2);
    send_cmd(OP_ADD, 64'h5555_AAAA_5555_AAAA, 32'hFFFF_FFFF);
    send_cmd(OP_ADD, 64'hAAAA_5555_AAAA_5555, 32'd3);
    send_cmd(OP_ADD, '1, 32'd1);
    send_cmd(OP_CANCEL, 64'hAAAA_5555_AAAA_5555, '0);
    send_cmd(OP_CANCEL, 64'hAAAA_5555_AAAA_5555, '0);
    send_cmd(OP_REFRESH, 64'hAAAA_5555_AAAA_5555, '0);
    send_cmd(OP_TICK, '0, '0);
    send_cmd(OP_TICK, '0, '0);
    send_cmd(OP_TICK, '0, '0);
    send_cmd(OP_REFRESH, 64'h5555_AAAA_5555_AAAA, '0);
    drain_results();

    // fill the table up with equal deadlines, overflow it, then expire those timers
    for (int i = 0; i < MAX_TIMERS; i++) send_cmd(OP_ADD, 64'(i) + 64'h100, 32'd1);
    send_cmd(OP_ADD, 64'h7777, 32'd1);
    send_cmd(OP_TICK, '0, '0);
    send_cmd(OP_TICK, '0, '0);
    drain_results();

    // random traffic, a stretch in the middle without gaps
    for (int n = 0; n < 330; n++) begin
      gaps_on = !(n >= 150 && n < 230);
      case ($urandom_range(9))
        0, 1, 2, 3: op = OP_ADD;
        4:          op = OP_REFRESH;
        5:          op = OP_CANCEL;
        default:    op = OP_TICK;
      endcase
      rid = ($urandom_range(19) == 0) ? {$urandom, $urandom} : id_pool[$urandom_range(39)];
      case ($urandom_range(9))
        0:       rtmo = '0;
        1:       rtmo = $urandom;
        default: rtmo = $urandom_range(1, 8);
      endcase
      send_cmd(op, rid, rtmo);
      if (n == 300) drain_results();
    end
    drain_results();

    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ timer_wheel_table.f @@
sv/twt_pkg.sv
sv/twt_cell.sv
sv/timer_wheel_table.sv
verif/twt_checker.sv
verif/tb_top.sv
